### sv/ppt_pkg.sv
`timescale 1ns / 1ps
// Shared constants and control/status types for the palindromic prime tester.
// No dependencies.
package ppt_pkg;

    localparam int VALUE_WIDTH = 20;
    localparam int MAX_DIGITS  = 7;

    // Trial divisor must reach just past sqrt(2^VALUE_WIDTH).
    localparam int DIV_W     = (VALUE_WIDTH + 1) / 2 + 1;
    localparam int SQ_W      = 2 * DIV_W;
    localparam int SQ_PAD    = SQ_W - VALUE_WIDTH;
    // Digit reversal of a value can exceed it by less than a factor of 16.
    localparam int REV_W     = VALUE_WIDTH + 4;
    localparam int CNT_W     = $clog2(MAX_DIGITS + 1);
    localparam int STEP_W    = $clog2(VALUE_WIDTH + 1);

    localparam int RADIX          = 10;
    localparam int FIRST_DIVISOR  = 3;
    localparam int FIRST_SQUARE   = 9;
    localparam int DIVISOR_STEP   = 2;

    // Divide by the radix as (x * ceil(2^k / 10)) >> k; k = width + 4 keeps it exact.
    localparam int              RECIP_SHIFT = VALUE_WIDTH + 4;
    localparam int              RECIP_W     = VALUE_WIDTH + 1;
    localparam int              PROD_W      = VALUE_WIDTH + RECIP_W;
    localparam longint unsigned RECIP_MULT  =
        ((64'd1 << RECIP_SHIFT) + RADIX - 1) / RADIX;

    typedef struct packed {
        logic load;          // capture a new request
        logic div_start;     // kick the trial divider
        logic digit_start;   // register rest / radix
        logic digit_step;    // consume one decimal digit
        logic next_divisor;  // advance to next odd divisor
        logic emit;          // register the result and strobe it
        logic pal;
        logic prime;
    } ppt_cmd_t;

    typedef struct packed {
        logic rest_zero;
        logic count_full;
        logic rev_eq;
        logic lt2;
        logic even;
        logic is_two;
        logic sq_le;
        logic div_done;
        logic rem_zero;
    } ppt_stat_t;

endpackage

### sv/ppt_divider.sv
`timescale 1ns / 1ps
// Bit-serial restoring divider, one quotient bit per cycle.
// Depends on ppt_pkg.
module ppt_divider
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    input  logic [ppt_pkg::VALUE_WIDTH-1:0]   dividend,
    input  logic [ppt_pkg::DIV_W-1:0]         divisor,
    output logic [ppt_pkg::DIV_W-1:0]         remainder,
    output logic                              done
);

    logic                            run_reg, run_next;
    logic                            done_reg, done_next;
    logic [ppt_pkg::STEP_W-1:0]      cnt_reg, cnt_next;
    logic [ppt_pkg::DIV_W-1:0]       rem_reg, rem_next;
    logic [ppt_pkg::VALUE_WIDTH-1:0] quo_reg, quo_next;
    logic [ppt_pkg::DIV_W-1:0]       den_reg, den_next;
    logic [ppt_pkg::DIV_W:0]         trial;
    logic [ppt_pkg::DIV_W:0]         diff;
    logic                            fits;

    always_comb
    begin
        trial = {rem_reg, quo_reg[ppt_pkg::VALUE_WIDTH-1]};
        diff  = trial - {1'b0, den_reg};
        fits  = (trial >= {1'b0, den_reg});

        run_next  = run_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        den_next  = den_reg;

        if (start)
        begin
            run_next = 1'b1;
            cnt_next = ppt_pkg::STEP_W'(ppt_pkg::VALUE_WIDTH);
            rem_next = '0;
            quo_next = dividend;
            den_next = divisor;
        end
        else if (run_reg)
        begin
            // remainder stays below the divisor, so DIV_W bits hold it
            rem_next = fits ? diff[ppt_pkg::DIV_W-1:0] : trial[ppt_pkg::DIV_W-1:0];
            quo_next = {quo_reg[ppt_pkg::VALUE_WIDTH-2:0], fits};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == ppt_pkg::STEP_W'(1))
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        den_reg <= den_next;
    end

    assign remainder = rem_reg;
    assign done      = done_reg;

endmodule

### sv/ppt_datapath.sv
`timescale 1ns / 1ps
// Datapath: held value, digit reversal, odd trial divisor with running square,
// result registers. Depends on ppt_pkg and ppt_divider.
module ppt_datapath
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  ppt_pkg::ppt_cmd_t                 cmd,
    output ppt_pkg::ppt_stat_t                stat,
    input  logic [ppt_pkg::VALUE_WIDTH-1:0]   number,
    output logic                              done,
    output logic [ppt_pkg::VALUE_WIDTH-1:0]   number_out,
    output logic                              is_palindrome,
    output logic                              is_prime,
    output logic                              is_both
);

    logic [ppt_pkg::VALUE_WIDTH-1:0] value_reg;
    logic [ppt_pkg::VALUE_WIDTH-1:0] rest_reg;
    logic [ppt_pkg::VALUE_WIDTH-1:0] q10_reg;
    logic [ppt_pkg::REV_W-1:0]       rev_reg;
    logic [ppt_pkg::CNT_W-1:0]       count_reg;
    logic [ppt_pkg::DIV_W-1:0]       d_reg;
    logic [ppt_pkg::SQ_W-1:0]        sq_reg;

    logic                            done_reg;
    logic [ppt_pkg::VALUE_WIDTH-1:0] num_out_reg;
    logic                            pal_reg;
    logic                            prime_reg;

    logic [ppt_pkg::DIV_W-1:0]       div_rem;
    logic                            div_done;
    logic [ppt_pkg::REV_W-1:0]       rev_times_ten;
    logic [ppt_pkg::PROD_W-1:0]      recip_prod;
    logic [3:0]                      q10_lo_times_ten;
    logic [3:0]                      digit;

    ppt_divider u_div
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (cmd.div_start),
        .dividend  (value_reg),
        .divisor   (d_reg),
        .remainder (div_rem),
        .done      (div_done)
    );

    assign rev_times_ten = (rev_reg << 3) + (rev_reg << 1);

    assign recip_prod = ppt_pkg::PROD_W'(rest_reg) * ppt_pkg::PROD_W'(ppt_pkg::RECIP_MULT);
    // the digit is below ten, so the low four bits of rest - 10*q are enough
    assign q10_lo_times_ten = (q10_reg[3:0] << 3) + (q10_reg[3:0] << 1);
    assign digit            = rest_reg[3:0] - q10_lo_times_ten;

    always_comb
    begin
        stat.rest_zero  = (rest_reg == '0);
        stat.count_full = (count_reg == ppt_pkg::CNT_W'(ppt_pkg::MAX_DIGITS));
        stat.rev_eq     = (rev_reg == {4'b0000, value_reg});
        stat.lt2        = (value_reg[ppt_pkg::VALUE_WIDTH-1:1] == '0);
        stat.even       = ~value_reg[0];
        stat.is_two     = (value_reg == ppt_pkg::VALUE_WIDTH'(2));
        stat.sq_le      = (sq_reg <= {{ppt_pkg::SQ_PAD{1'b0}}, value_reg});
        stat.div_done   = div_done;
        stat.rem_zero   = (div_rem == '0);
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            value_reg <= number;
            rest_reg  <= number;
            rev_reg   <= '0;
            count_reg <= '0;
            d_reg     <= ppt_pkg::DIV_W'(ppt_pkg::FIRST_DIVISOR);
            sq_reg    <= ppt_pkg::SQ_W'(ppt_pkg::FIRST_SQUARE);
        end
        else
        begin
            if (cmd.digit_start)
            begin
                q10_reg <= ppt_pkg::VALUE_WIDTH'(recip_prod >> ppt_pkg::RECIP_SHIFT);
            end
            if (cmd.digit_step)
            begin
                rest_reg  <= q10_reg;
                rev_reg   <= rev_times_ten + {{(ppt_pkg::REV_W-4){1'b0}}, digit};
                count_reg <= count_reg + 1'b1;
            end
            if (cmd.next_divisor)
            begin
                // (d+2)^2 = d^2 + 4d + 4
                d_reg  <= d_reg + ppt_pkg::DIV_W'(ppt_pkg::DIVISOR_STEP);
                sq_reg <= sq_reg + {{(ppt_pkg::SQ_W-ppt_pkg::DIV_W){1'b0}}, d_reg} * 3'd4
                          + ppt_pkg::SQ_W'(4);
            end
        end
        if (cmd.emit)
        begin
            num_out_reg <= value_reg;
            pal_reg     <= cmd.pal;
            prime_reg   <= cmd.prime;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= cmd.emit;
        end
    end

    assign done          = done_reg;
    assign number_out    = num_out_reg;
    assign is_palindrome = pal_reg;
    assign is_prime      = prime_reg;
    assign is_both       = pal_reg & prime_reg;

endmodule

### sv/ppt_ctrl.sv
`timescale 1ns / 1ps
// Controller: sequences digit reversal, then trial division, then the result.
// Depends on ppt_pkg.
module ppt_ctrl
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  ppt_pkg::ppt_stat_t stat,
    output ppt_pkg::ppt_cmd_t  cmd
);

    typedef enum logic [2:0]
    {
        IDLE,
        DIG_CHECK,
        DIG_WAIT,
        PRM_CHECK,
        PRM_WAIT
    } state_t;

    state_t state_reg, state_next;
    logic   pal_reg, pal_next;
    logic   busy_reg;

    always_comb
    begin
        state_next = state_reg;
        pal_next   = pal_reg;
        cmd        = '0;
        cmd.pal    = pal_reg;

        case (state_reg)
            IDLE:
            begin
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = DIG_CHECK;
                end
            end
            DIG_CHECK:
            begin
                if (!stat.rest_zero && !stat.count_full)
                begin
                    cmd.digit_start = 1'b1;
                    state_next      = DIG_WAIT;
                end
                else
                begin
                    // digits left over means too many digits: not a palindrome
                    pal_next   = stat.rest_zero & stat.rev_eq;
                    state_next = PRM_CHECK;
                end
            end
            DIG_WAIT:
            begin
                cmd.digit_step = 1'b1;
                state_next     = DIG_CHECK;
            end
            PRM_CHECK:
            begin
                if (stat.lt2)
                begin
                    cmd.emit   = 1'b1;
                    cmd.prime  = 1'b0;
                    state_next = IDLE;
                end
                else if (stat.even)
                begin
                    cmd.emit   = 1'b1;
                    cmd.prime  = stat.is_two;
                    state_next = IDLE;
                end
                else if (stat.sq_le)
                begin
                    cmd.div_start = 1'b1;
                    state_next    = PRM_WAIT;
                end
                else
                begin
                    cmd.emit   = 1'b1;
                    cmd.prime  = 1'b1;
                    state_next = IDLE;
                end
            end
            PRM_WAIT:
            begin
                if (stat.div_done)
                begin
                    if (stat.rem_zero)
                    begin
                        cmd.emit   = 1'b1;
                        cmd.prime  = 1'b0;
                        state_next = IDLE;
                    end
                    else
                    begin
                        cmd.next_divisor = 1'b1;
                        state_next       = PRM_CHECK;
                    end
                end
            end
            default:
            begin
                state_next = IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= IDLE;
            pal_reg   <= 1'b0;
            busy_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            pal_reg   <= pal_next;
            busy_reg  <= (state_next != IDLE);
        end
    end

    assign busy = busy_reg;

endmodule

### sv/palindromic_prime_test_unit.sv
`timescale 1ns / 1ps
// Top level of the palindromic prime tester: controller plus datapath.
// Depends on ppt_pkg, ppt_ctrl, ppt_datapath.

// A request is taken when start is high while busy is low; busy then stays high
// until the answer is out. Each request produces one result, shown for a single
// cycle with done high; the receiver cannot stall it, so it must capture it then.
// Decimal digits are peeled off by a reciprocal multiply, one per DIG_CHECK, DIG_WAIT pass.
// The rest of the run is set by the bit-serial trial divider, started once per
// odd trial divisor d = 3, 5, ... while d*d <= number and no remainder is zero;
// a prime near 2^20 takes about 511 divisions. Even numbers and numbers below 2
// finish right after the digit pass.
module palindromic_prime_test_unit
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic [ppt_pkg::VALUE_WIDTH-1:0]   number,
    output logic                              done,
    output logic [ppt_pkg::VALUE_WIDTH-1:0]   number_out,
    output logic                              is_palindrome,
    output logic                              is_prime,
    output logic                              is_both
);

    ppt_pkg::ppt_cmd_t  cmd;
    ppt_pkg::ppt_stat_t stat;

    ppt_ctrl u_ctrl
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .stat  (stat),
        .cmd   (cmd)
    );

    ppt_datapath u_dp
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .stat          (stat),
        .number        (number),
        .done          (done),
        .number_out    (number_out),
        .is_palindrome (is_palindrome),
        .is_prime      (is_prime),
        .is_both       (is_both)
    );

endmodule

### tb/sv/palindromic_prime_test_unit_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for palindromic_prime_test_unit: directed table, then random values.
// Depends on ppt_pkg and palindromic_prime_test_unit.
module palindromic_prime_test_unit_tb;

    localparam int W = ppt_pkg::VALUE_WIDTH;
    localparam int PROBE_COUNT = 24;
    localparam int RANDOM_REQUESTS = 76;

    typedef struct packed {
        logic [W-1:0] value;
        logic         pal;
        logic         prime;
        logic         both;
    } verdict_t;

    typedef struct packed {
        logic [W-1:0] value;
        logic         has_answer;
        logic         pal;
        logic         prime;
    } probe_t;

    logic         clk = 1'b0;
    logic         rst_n = 1'b0;
    logic         start = 1'b0;
    logic [W-1:0] number = '0;
    logic         busy;
    logic         done;
    logic [W-1:0] number_out;
    logic         is_palindrome;
    logic         is_prime;
    logic         is_both;

    verdict_t pending_verdicts [$];
    int       mismatches = 0;
    int       burst_left = 0;

    // Answers are typed in only where they are obvious; other rows use classify_number.
    probe_t probe_table [PROBE_COUNT] = '{
        '{20'd0,       1'b1, 1'b1, 1'b0},
        '{20'd1,       1'b1, 1'b1, 1'b0},
        '{20'd2,       1'b1, 1'b1, 1'b1},
        '{20'd3,       1'b1, 1'b1, 1'b1},
        '{20'd4,       1'b1, 1'b1, 1'b0},
        '{20'd9,       1'b1, 1'b1, 1'b0},
        '{20'd10,      1'b0, 1'b0, 1'b0},
        '{20'd11,      1'b1, 1'b1, 1'b1},
        '{20'd25,      1'b0, 1'b0, 1'b0},
        '{20'd49,      1'b0, 1'b0, 1'b0},
        '{20'd101,     1'b0, 1'b0, 1'b0},
        '{20'd121,     1'b0, 1'b0, 1'b0},
        '{20'd131,     1'b0, 1'b0, 1'b0},
        '{20'd929,     1'b0, 1'b0, 1'b0},
        '{20'd961,     1'b0, 1'b0, 1'b0},
        '{20'd98689,   1'b0, 1'b0, 1'b0},
        '{20'd524288,  1'b0, 1'b0, 1'b0},
        '{20'd699050,  1'b0, 1'b0, 1'b0},
        '{20'd349525,  1'b0, 1'b0, 1'b0},
        '{20'd999999,  1'b0, 1'b0, 1'b0},
        '{20'd1000001, 1'b0, 1'b0, 1'b0},
        '{20'd1003001, 1'b0, 1'b0, 1'b0},
        '{20'd1048573, 1'b0, 1'b0, 1'b0},
        '{20'd1048575, 1'b1, 1'b0, 1'b0}
    };

    palindromic_prime_test_unit uut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .number        (number),
        .done          (done),
        .number_out    (number_out),
        .is_palindrome (is_palindrome),
        .is_prime      (is_prime),
        .is_both       (is_both)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    function automatic verdict_t classify_number(input logic [W-1:0] n);
        verdict_t        r;
        int unsigned     rest;
        int unsigned     digits [ppt_pkg::MAX_DIGITS];
        int              count;
        int              lo;
        int              hi;
        longint unsigned d;
        r.value = n;
        r.pal   = 1'b1;
        rest    = n;
        count   = 0;
        while (rest > 0 && count < ppt_pkg::MAX_DIGITS)
        begin
            digits[count] = rest % 10;
            rest          = rest / 10;
            count++;
        end
        // more digits than the store holds reads as not a palindrome
        if (rest > 0)
            r.pal = 1'b0;
        lo = 0;
        hi = count;
        while (r.pal && lo + 1 < hi)
        begin
            if (digits[lo] != digits[hi-1])
                r.pal = 1'b0;
            lo++;
            hi--;
        end
        if (n < 2)
            r.prime = 1'b0;
        else if (n[0] == 1'b0)
            r.prime = (n == 2);
        else
        begin
            r.prime = 1'b1;
            d = 3;
            while (r.prime && d * d <= n)
            begin
                if (n % d == 0)
                    r.prime = 1'b0;
                d += 2;
            end
        end
        r.both = r.pal & r.prime;
        return r;
    endfunction

    // Holds start until the request is taken, then maybe opens a gap before the next one.
    task automatic issue_request(input logic [W-1:0] n, input verdict_t want);
        int gap;
        start  <= 1'b1;
        number <= n;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        pending_verdicts.push_back(want);
        if (burst_left > 0)
            burst_left--;
        else
        begin
            start <= 1'b0;
            gap = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 800) : $urandom_range(1, 40);
            repeat (gap)
                @(posedge clk);
            burst_left = $urandom_range(0, 6);
        end
    endtask

    task automatic report_field(input string field, input longint unsigned got,
                                input longint unsigned want, input logic [W-1:0] n);
        if (mismatches < 10)
            $display("MISMATCH %s for number %0d: expected %0d, got %0d", field, n, want, got);
        mismatches++;
    endtask

    always @(posedge clk)
    begin : check_result
        verdict_t want;
        if (rst_n && done)
        begin
            if (pending_verdicts.size() == 0)
            begin
                if (mismatches < 10)
                    $display("MISMATCH unexpected result for number %0d", number_out);
                mismatches++;
            end
            else
            begin
                want = pending_verdicts.pop_front();
                if (number_out !== want.value)
                    report_field("number_out", number_out, want.value, want.value);
                if (is_palindrome !== want.pal)
                    report_field("is_palindrome", is_palindrome, want.pal, want.value);
                if (is_prime !== want.prime)
                    report_field("is_prime", is_prime, want.prime, want.value);
                if (is_both !== want.both)
                    report_field("is_both", is_both, want.both, want.value);
            end
        end
    end

    initial
    begin
        int           i;
        int           k;
        int           len;
        int           half_len;
        int unsigned  half [4];
        int unsigned  v;
        verdict_t     want;
        repeat (8)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (i = 0; i < PROBE_COUNT; i++)
        begin
            if (probe_table[i].has_answer)
                want = '{probe_table[i].value, probe_table[i].pal, probe_table[i].prime,
                         probe_table[i].pal & probe_table[i].prime};
            else
                want = classify_number(probe_table[i].value);
            issue_request(probe_table[i].value, want);
        end

        // mostly small or palindromic values; a few full-range ones reach the long trial loops
        for (i = 0; i < RANDOM_REQUESTS; i++)
        begin
            case ($urandom_range(0, 9))
                0, 1, 2: v = $urandom_range(0, 4095) | 1;
                3:       v = $urandom_range(0, 65535);
                4, 5, 6:
                begin
                    len      = $urandom_range(1, 7);
                    half_len = (len + 1) / 2;
                    for (k = 0; k < half_len; k++)
                        half[k] = $urandom_range(0, 9);
                    if (len == 7)
                    begin
                        half[0] = 1;
                        half[1] = 0;
                        half[2] = $urandom_range(0, 3);
                    end
                    else if (len > 1 && half[0] == 0)
                        half[0] = $urandom_range(1, 9);
                    v = 0;
                    for (k = 0; k < len; k++)
                        v = v * 10 + half[(k < half_len) ? k : len - 1 - k];
                end
                7:       v = $urandom_range(0, 15);
                default: v = $urandom_range(0, (1 << W) - 1);
            endcase
            issue_request(v[W-1:0], classify_number(v[W-1:0]));
        end
        start <= 1'b0;

        while (pending_verdicts.size() != 0)
            @(posedge clk);
        repeat (100)
            @(posedge clk);

        if (mismatches == 0 && pending_verdicts.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    // Slowest run of about 100 requests at the 4 ns clock is near 5 ms.
    initial
    begin
        #(50_000_000);
        $display("Test completed with failures");
        $finish;
    end

endmodule
